[sv/efpt_pkg.sv]
// efpt_pkg: constants, types and the arctangent table for the marker-frame point transform
// used by every module of the block; depends on nothing
package efpt_pkg;

  localparam int CordicStages = 16;
  localparam int TableLen = 24;
  localparam int NumStages = (CordicStages < TableLen) ? CordicStages : TableLen;
  localparam int PosW = 24;
  localparam int AngW = 16;
  localparam int DiffW = 25;
  localparam int CsW = 32;
  localparam int ZW = 26;
  localparam int VecW = 28;
  localparam int ProdW = 62;
  localparam logic signed [CsW-1:0] GainQ30 = 32'sd652032874;
  localparam logic signed [17:0] FullTurn = 18'sd46080;
  localparam logic signed [17:0] HalfTurn = 18'sd23040;
  localparam logic signed [17:0] QuarterTurn = 18'sd11520;
  localparam logic signed [PosW-1:0] PosMax = 24'sh7FFFFF;
  localparam logic signed [PosW-1:0] PosMin = -24'sh800000;

  typedef logic signed [CsW-1:0] cs_t;
  typedef logic signed [ZW-1:0] z_t;

  typedef struct packed {
    cs_t x;
    cs_t y;
    z_t z;
    logic flip;
  } cordic_t;

  function automatic z_t atan_deg16(input int i);
    z_t r;
    case (i)
      0: r = 26'sd2949120;
      1: r = 26'sd1740967;
      2: r = 26'sd919879;
      3: r = 26'sd466945;
      4: r = 26'sd234379;
      5: r = 26'sd117304;
      6: r = 26'sd58666;
      7: r = 26'sd29335;
      8: r = 26'sd14668;
      9: r = 26'sd7334;
      10: r = 26'sd3667;
      11: r = 26'sd1833;
      12: r = 26'sd917;
      13: r = 26'sd458;
      14: r = 26'sd229;
      15: r = 26'sd115;
      16: r = 26'sd57;
      17: r = 26'sd29;
      18: r = 26'sd14;
      19: r = 26'sd7;
      20: r = 26'sd4;
      21: r = 26'sd2;
      22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

[sv/euler_frame_point_transform_top.sv]
// euler_frame_point_transform_top: marker-frame point transform, subtract then z/y/x rotations
// depends on efpt_pkg, efpt_sincos, efpt_rot
// NumStages cordic cells, three rotations (products registered, then the rounded sum)
// and one output register lie between the input transfer and out_valid_o
// throughput: one transfer per cycle unless the output stalls, set by the pipelined cordic chain
// the whole pipe advances together whenever the output register is free or being taken
// reset clears only the valid bits; data registers are not reset
module euler_frame_point_transform_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [23:0]      stylus_x_i,
  input  logic signed [23:0]      stylus_y_i,
  input  logic signed [23:0]      stylus_z_i,
  input  logic signed [23:0]      marker_x_i,
  input  logic signed [23:0]      marker_y_i,
  input  logic signed [23:0]      marker_z_i,
  input  logic signed [15:0]      marker_azimuth_i,
  input  logic signed [15:0]      marker_elevation_i,
  input  logic signed [15:0]      marker_roll_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [23:0]      local_x_o,
  output logic signed [23:0]      local_y_o,
  output logic signed [23:0]      local_z_o
);

  localparam int N = efpt_pkg::NumStages;
  localparam int Lat = N + 6;
  localparam int W = efpt_pkg::VecW;

  // pipe advances when the output register is empty or being drained
  logic adv;
  logic [Lat-1:0] vld_q;
  logic out_vld_q;
  assign adv = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // difference vector, delayed alongside the cordic chain
  logic signed [efpt_pkg::DiffW-1:0] dx_q [N];
  logic signed [efpt_pkg::DiffW-1:0] dy_q [N];
  logic signed [efpt_pkg::DiffW-1:0] dz_q [N];
  logic signed [15:0] el_q [2];
  logic signed [15:0] ro_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q[0] <= efpt_pkg::DiffW'(stylus_x_i) - efpt_pkg::DiffW'(marker_x_i);
      dy_q[0] <= efpt_pkg::DiffW'(stylus_y_i) - efpt_pkg::DiffW'(marker_y_i);
      dz_q[0] <= efpt_pkg::DiffW'(stylus_z_i) - efpt_pkg::DiffW'(marker_z_i);
      for (int i = 1; i < N; i++) begin
        dx_q[i] <= dx_q[i-1];
        dy_q[i] <= dy_q[i-1];
        dz_q[i] <= dz_q[i-1];
      end
      el_q[0] <= marker_elevation_i;
      ro_q[0] <= marker_roll_i;
      for (int i = 1; i < 2; i++) el_q[i] <= el_q[i-1];
      for (int i = 1; i < 4; i++) ro_q[i] <= ro_q[i-1];
    end
  end

  // three cordic chains: azimuth starts with the sample, the others later so that
  // each sine and cosine meets its rotation stage
  efpt_pkg::cs_t ca, sa, ce, se, cr, sr;
  efpt_sincos u_az (.clk_i(clk_i), .en_i(adv), .ang_i(marker_azimuth_i),
                    .cos_o(ca), .sin_o(sa));
  efpt_sincos u_el (.clk_i(clk_i), .en_i(adv), .ang_i(el_q[1]),
                    .cos_o(ce), .sin_o(se));
  efpt_sincos u_ro (.clk_i(clk_i), .en_i(adv), .ang_i(ro_q[3]),
                    .cos_o(cr), .sin_o(sr));

  // z rotation first, then y, then x; the coordinate each one skips is delayed to meet it
  logic signed [W-1:0] x1, y1, z1_q [2], z2, x2, y2_q [2], y3, z3, x3_q [2];

  efpt_rot u_rz (.clk_i(clk_i), .en_i(adv), .cos_i(ca), .sin_i(sa),
                 .p_i(W'(dx_q[N-1])), .q_i(W'(dy_q[N-1])), .p_o(x1), .q_o(y1));
  efpt_rot u_ry (.clk_i(clk_i), .en_i(adv), .cos_i(ce), .sin_i(se),
                 .p_i(z1_q[1]), .q_i(x1), .p_o(z2), .q_o(x2));
  efpt_rot u_rx (.clk_i(clk_i), .en_i(adv), .cos_i(cr), .sin_i(sr),
                 .p_i(y2_q[1]), .q_i(z2), .p_o(y3), .q_o(z3));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      z1_q[0] <= W'(dz_q[N-1]);
      z1_q[1] <= z1_q[0];
      y2_q[0] <= y1;
      y2_q[1] <= y2_q[0];
      x3_q[0] <= x2;
      x3_q[1] <= x3_q[0];
    end
  end

  function automatic logic signed [23:0] sat(input logic signed [W-1:0] v);
    logic signed [23:0] r;
    if (v > W'(efpt_pkg::PosMax)) r = efpt_pkg::PosMax;
    else if (v < W'(efpt_pkg::PosMin)) r = efpt_pkg::PosMin;
    else r = v[23:0];
    return r;
  endfunction

  logic signed [23:0] lx_q, ly_q, lz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lx_q <= sat(x3_q[1]);
      ly_q <= sat(y3);
      lz_q <= sat(z3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  assign out_valid_o = out_vld_q;
  assign local_x_o = lx_q;
  assign local_y_o = ly_q;
  assign local_z_o = lz_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && $stable(lx_q))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow output register");
  a_pipe_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipe moved during stall");
`endif

endmodule

[sv/efpt_cell.sv]
// efpt_cell: one cordic micro-rotation cell, registered, stage index tied off per instance
// depends on efpt_pkg
module efpt_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [4:0]       stage_i,
  input  efpt_pkg::cordic_t c_i,
  output efpt_pkg::cordic_t c_o
);

  efpt_pkg::cordic_t c_d, c_q;

  always_comb begin
    c_d = c_i;
    if (!c_i.z[efpt_pkg::ZW-1]) begin
      c_d.x = c_i.x - (c_i.y >>> stage_i);
      c_d.y = c_i.y + (c_i.x >>> stage_i);
      c_d.z = c_i.z - efpt_pkg::atan_deg16(int'(stage_i));
    end else begin
      c_d.x = c_i.x + (c_i.y >>> stage_i);
      c_d.y = c_i.y - (c_i.x >>> stage_i);
      c_d.z = c_i.z + efpt_pkg::atan_deg16(int'(stage_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) c_q <= c_d;
  end

  assign c_o = c_q;

endmodule

[sv/efpt_sincos.sv]
// efpt_sincos: angle folding and a chain of cordic cells giving q30 cosine and sine
// depends on efpt_pkg and efpt_cell
module efpt_sincos (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [efpt_pkg::AngW-1:0]    ang_i,
  output efpt_pkg::cs_t                       cos_o,
  output efpt_pkg::cs_t                       sin_o
);

  efpt_pkg::cordic_t chain [efpt_pkg::NumStages+1];
  logic signed [17:0] a;
  logic flip;

  always_comb begin
    a = -{{2{ang_i[efpt_pkg::AngW-1]}}, ang_i};
    flip = 1'b0;
    if (a >= efpt_pkg::HalfTurn) a = a - efpt_pkg::FullTurn;
    if (a < -efpt_pkg::HalfTurn) a = a + efpt_pkg::FullTurn;
    if (a > efpt_pkg::QuarterTurn) begin
      a = a - efpt_pkg::HalfTurn;
      flip = 1'b1;
    end
    if (a < -efpt_pkg::QuarterTurn) begin
      a = a + efpt_pkg::HalfTurn;
      flip = 1'b1;
    end
    chain[0].x = efpt_pkg::GainQ30;
    chain[0].y = '0;
    chain[0].z = efpt_pkg::z_t'({{(efpt_pkg::ZW-18){a[17]}}, a} <<< 9);
    chain[0].flip = flip;
  end

  for (genvar g = 0; g < efpt_pkg::NumStages; g++) begin : g_cell
    efpt_cell u_cell (
      .clk_i(clk_i), .en_i(en_i), .stage_i(5'(g)), .c_i(chain[g]), .c_o(chain[g+1])
    );
  end

  assign cos_o = chain[efpt_pkg::NumStages].flip ? -chain[efpt_pkg::NumStages].x
                                                 : chain[efpt_pkg::NumStages].x;
  assign sin_o = chain[efpt_pkg::NumStages].flip ? -chain[efpt_pkg::NumStages].y
                                                 : chain[efpt_pkg::NumStages].y;

endmodule

[sv/efpt_rot.sv]
// efpt_rot: one plane rotation, products registered then summed and rounded
// depends on efpt_pkg
module efpt_rot (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  efpt_pkg::cs_t                      cos_i,
  input  efpt_pkg::cs_t                      sin_i,
  input  logic signed [efpt_pkg::VecW-1:0]   p_i,
  input  logic signed [efpt_pkg::VecW-1:0]   q_i,
  output logic signed [efpt_pkg::VecW-1:0]   p_o,
  output logic signed [efpt_pkg::VecW-1:0]   q_o
);

  logic signed [efpt_pkg::ProdW-1:0] cp_q, sq_q, sp_q, cq_q;
  logic signed [efpt_pkg::ProdW:0] np, nq;
  logic signed [efpt_pkg::VecW-1:0] p_q, q_q;

  localparam logic signed [efpt_pkg::ProdW:0] Half = 63'sd1 <<< 29;

  always_comb begin
    np = cp_q - sq_q + Half;
    nq = sp_q + cq_q + Half;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cp_q <= efpt_pkg::ProdW'(cos_i * p_i);
      sq_q <= efpt_pkg::ProdW'(sin_i * q_i);
      sp_q <= efpt_pkg::ProdW'(sin_i * p_i);
      cq_q <= efpt_pkg::ProdW'(cos_i * q_i);
      p_q  <= np[30 +: efpt_pkg::VecW];
      q_q  <= nq[30 +: efpt_pkg::VecW];
    end
  end

  assign p_o = p_q;
  assign q_o = q_q;

endmodule

[dv/euler_frame_point_transform_checker.sv]
// checker for the marker-frame point transform: watches both channels, predicts each point
// in the marker frame with its own cordic and rotation arithmetic, and counts mismatches
// depends on efpt_pkg for the stage count and the arctangent table
module euler_frame_point_transform_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [23:0] stylus_x_i,
  input  logic signed [23:0] stylus_y_i,
  input  logic signed [23:0] stylus_z_i,
  input  logic signed [23:0] marker_x_i,
  input  logic signed [23:0] marker_y_i,
  input  logic signed [23:0] marker_z_i,
  input  logic signed [15:0] marker_azimuth_i,
  input  logic signed [15:0] marker_elevation_i,
  input  logic signed [15:0] marker_roll_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [23:0] local_x_i,
  input  logic signed [23:0] local_y_i,
  input  logic signed [23:0] local_z_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 points_checked_o
);

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } point_t;

  point_t expected_points[$];

  // angle in 1/128 degree, already negated; q30 cosine and sine
  task automatic cordic_sincos(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit flip;
    x = efpt_pkg::GainQ30;
    y = 0;
    flip = 0;
    if (ang >= 23040) ang -= 46080;
    if (ang < -23040) ang += 46080;
    if (ang > 11520) begin
      ang -= 23040;
      flip = 1;
    end
    if (ang < -11520) begin
      ang += 23040;
      flip = 1;
    end
    z = ang * 512;
    for (int i = 0; i < efpt_pkg::NumStages; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(efpt_pkg::atan_deg16(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(efpt_pkg::atan_deg16(i));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint round_q30(input longint v);
    return (v + (longint'(1) << 29)) >>> 30;
  endfunction

  task automatic rotate_plane(inout longint p, inout longint q, input longint c, input longint s);
    longint np;
    np = round_q30(c * p - s * q);
    q = round_q30(s * p + c * q);
    p = np;
  endtask

  function automatic logic signed [23:0] clamp_pos(input longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return -24'sh800000;
    return v[23:0];
  endfunction

  task automatic predict_local_point();
    longint dx, dy, dz, c, s;
    point_t p;
    dx = longint'(stylus_x_i) - longint'(marker_x_i);
    dy = longint'(stylus_y_i) - longint'(marker_y_i);
    dz = longint'(stylus_z_i) - longint'(marker_z_i);
    cordic_sincos(-longint'(marker_azimuth_i), c, s);
    rotate_plane(dx, dy, c, s);
    cordic_sincos(-longint'(marker_elevation_i), c, s);
    rotate_plane(dz, dx, c, s);
    cordic_sincos(-longint'(marker_roll_i), c, s);
    rotate_plane(dy, dz, c, s);
    p.x = clamp_pos(dx);
    p.y = clamp_pos(dy);
    p.z = clamp_pos(dz);
    expected_points.push_back(p);
  endtask

  assign pending_o = expected_points.size();

  always @(posedge clk_i) begin
    point_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      points_checked_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_local_point();
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result x=%0d y=%0d z=%0d", local_x_i, local_y_i, local_z_i);
          fail_count_o++;
        end else begin
          e = expected_points.pop_front();
          points_checked_o++;
          if (local_x_i !== e.x) begin
            $error("local_x expected %0d got %0d", e.x, local_x_i);
            fail_count_o++;
          end
          if (local_y_i !== e.y) begin
            $error("local_y expected %0d got %0d", e.y, local_y_i);
            fail_count_o++;
          end
          if (local_z_i !== e.z) begin
            $error("local_z expected %0d got %0d", e.z, local_z_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

[dv/euler_frame_point_transform_top_tb.sv]
// testbench top for the marker-frame point transform: directed and random samples with
// bursty input, patterned output stalls and one long hold-off; depends on the checker and efpt_pkg
module euler_frame_point_transform_top_tb;

  localparam int RandomSamples = 1730;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = efpt_pkg::NumStages + 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [23:0] stylus_x_i = '0, stylus_y_i = '0, stylus_z_i = '0;
  logic signed [23:0] marker_x_i = '0, marker_y_i = '0, marker_z_i = '0;
  logic signed [15:0] marker_azimuth_i = '0, marker_elevation_i = '0, marker_roll_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [23:0] local_x_o, local_y_o, local_z_o;

  int fail_count, pending, points_checked;
  int samples_sent = 0;
  int idle_cycles = 0;
  bit stimulus_done = 0;
  bit hold_off_req = 0;

  always #1 clk_i = ~clk_i;

  euler_frame_point_transform_top uut (.*);

  euler_frame_point_transform_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .stylus_x_i, .stylus_y_i, .stylus_z_i, .marker_x_i, .marker_y_i, .marker_z_i,
    .marker_azimuth_i, .marker_elevation_i, .marker_roll_i,
    .out_valid_i(out_valid_o), .out_ready_i, .local_x_i(local_x_o), .local_y_i(local_y_o),
    .local_z_i(local_z_o), .fail_count_o(fail_count), .pending_o(pending),
    .points_checked_o(points_checked)
  );

  // one sample as a struct so directed and random parts share the driver
  typedef struct {
    logic signed [23:0] sx, sy, sz, mx, my, mz;
    logic signed [15:0] az, el, rl;
  } sample_t;

  function automatic logic signed [23:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return 24'($signed($urandom_range(0, 4000)) - 2000);
      default: return 24'($urandom);
    endcase
  endfunction

  // mostly stated range, sometimes anywhere in 16 bits, sometimes on a boundary
  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 6))
          0: return 16'sd11520;
          1: return -16'sd11520;
          2: return 16'sd23040;
          3: return -16'sd23040;
          4: return 16'sh7FFF;
          5: return -16'sh8000;
          default: return 16'sd0;
        endcase
      end
      default: return 16'($signed($urandom_range(0, 46080)) - 23040);
    endcase
  endfunction

  // hold the sample until the handshake completes; valid is not dropped between back-to-back
  // transfers, and when keep_valid is clear valid is dropped and held low before the next sample
  task automatic send_sample(input sample_t s, input bit keep_valid);
    in_valid_i <= 1'b1;
    stylus_x_i <= s.sx; stylus_y_i <= s.sy; stylus_z_i <= s.sz;
    marker_x_i <= s.mx; marker_y_i <= s.my; marker_z_i <= s.mz;
    marker_azimuth_i <= s.az; marker_elevation_i <= s.el; marker_roll_i <= s.rl;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
    if (!keep_valid) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic sample_t make_sample(input logic signed [23:0] sx, sy, sz, mx, my, mz,
                                          input logic signed [15:0] az, el, rl);
    sample_t s;
    s.sx = sx; s.sy = sy; s.sz = sz; s.mx = mx; s.my = my; s.mz = mz;
    s.az = az; s.el = el; s.rl = rl;
    return s;
  endfunction

  // receiver: stall pattern, plus one long hold-off on request
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_off_req = 0;
      end
      phase = (phase + 1) % 512;
      if (phase < 128) out_ready_i <= 1'b1;                // stretch with no stalls
      else if (phase < 320) out_ready_i <= ($urandom_range(0, 3) != 0);
      else out_ready_i <= ($urandom_range(0, 1) != 0);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("euler_frame_point_transform_top_tb: errors");
      $finish;
    end
  end

  initial begin
    sample_t s;
    int burst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, extremes, quarter and half turns, wrap-around angles, saturation
    send_sample(make_sample('0, '0, '0, '0, '0, '0, '0, '0, '0), 0);
    send_sample(make_sample(24'sd1024, 24'sd2048, -24'sd512, 0, 0, 0, 16'sd11520, 0, 0), 0);
    send_sample(make_sample(24'sd1024, 24'sd2048, -24'sd512, 0, 0, 0, 0, 16'sd11520, 0), 1);
    send_sample(make_sample(24'sd1024, 24'sd2048, -24'sd512, 0, 0, 0, 0, 0, 16'sd11520), 1);
    send_sample(make_sample(24'sd1000, 24'sd3, 24'sd7, 0, 0, 0, 16'sd23040, -16'sd23040,
                            16'sd11521), 0);
    send_sample(make_sample(24'sd1000, 24'sd3, 24'sd7, 0, 0, 0, -16'sd11521, 16'sd11519,
                            -16'sd23039), 0);
    send_sample(make_sample(24'sd500, -24'sd500, 24'sd9, 24'sd1, 24'sd2, 24'sd3, 16'sh7FFF,
                            -16'sh8000, 16'sd30000), 0);
    send_sample(make_sample(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000,
                            -24'sh800000, 0, 0, 0), 1);
    send_sample(make_sample(-24'sh800000, -24'sh800000, -24'sh800000, 24'sh7FFFFF,
                            24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0), 1);
    send_sample(make_sample(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF,
                            -24'sh800000, 16'sd5760, 16'sd5760, 16'sd5760), 0);
    send_sample(make_sample(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 16'sd5760,
                            -16'sd5760, 16'sd17280), 0);
    send_sample(make_sample(-24'sd1, -24'sd1, -24'sd1, 0, 0, 0, -16'sd1, 16'sd1, -16'sd1), 0);
    send_sample(make_sample(24'sh555555, -24'sh2AAAAB, 24'sh123456, -24'sh2AAAAB, 24'sh555555,
                            24'sh0F0F0F, 16'sh5555, -16'sh5556, 16'sh2AAA), 0);

    // random: bursts with gaps; long receiver hold-off part way through
    while (samples_sent < RandomSamples + 13) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) begin
        s = make_sample(rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                        rand_angle(), rand_angle(), rand_angle());
        if (samples_sent == 600) hold_off_req = 1;
        send_sample(s, i != burst - 1);
      end
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    stimulus_done = 1;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d samples (directed and random, angles past the quarter and half turns,",
             samples_sent);
    $display("  saturating positions, output stalls and a long hold-off), %0d points checked",
             points_checked);
    if (fail_count == 0) $display("euler_frame_point_transform_top_tb: clean");
    else $display("euler_frame_point_transform_top_tb: errors");
    $finish;
  end

endmodule
